### design/bawt_pkg.sv
// Shared types, codes and address-map constants for the bus access decoder.
`default_nettype none

package bawt_pkg;

	// Bus command codes; the fourth code is ignored
	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_IDLE  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Access size codes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	// Routing targets
	typedef enum logic [3:0] {
		TGT_NONE      = 4'd0,
		TGT_BOOT_ROM  = 4'd1,
		TGT_EXT_RAM   = 4'd2,
		TGT_INT_RAM   = 4'd3,
		TGT_IO_REG    = 4'd4,
		TGT_IO_MIRROR = 4'd5,
		TGT_IO_UNMAP  = 4'd6,
		TGT_PALETTE   = 4'd7,
		TGT_VRAM      = 4'd8,
		TGT_OAM       = 4'd9,
		TGT_CART      = 4'd10
	} tgt_t;

	// Map slots selected by address bits 26:24 outside cartridge space
	localparam logic [2:0] MAP_BOOT_LO = 3'd0;
	localparam logic [2:0] MAP_BOOT_HI = 3'd1;
	localparam logic [2:0] MAP_EXT_RAM = 3'd2;
	localparam logic [2:0] MAP_INT_RAM = 3'd3;
	localparam logic [2:0] MAP_IO      = 3'd4;
	localparam logic [2:0] MAP_PALETTE = 3'd5;
	localparam logic [2:0] MAP_VRAM    = 3'd6;
	localparam logic [2:0] MAP_OAM     = 3'd7;

	// Configuration register indexes
	localparam logic [2:0] IDX_NWAIT0 = 3'd0;
	localparam logic [2:0] IDX_NWAIT1 = 3'd1;
	localparam logic [2:0] IDX_NWAIT2 = 3'd2;
	localparam logic [2:0] IDX_NWAIT3 = 3'd3;
	localparam logic [2:0] IDX_SWAIT0 = 3'd4;
	localparam logic [2:0] IDX_SWAIT1 = 3'd5;
	localparam logic [2:0] IDX_SWAIT2 = 3'd6;
	localparam logic [2:0] IDX_SWAIT3 = 3'd7;

	localparam int CART_BIT = 27;
	localparam logic [3:0] NWAIT_RESET = 4'd5;
	localparam logic [3:0] SWAIT_RESET = 4'd3;

	// Address masks and match values
	localparam logic [31:0] SEQ_BOUND_MASK = 32'h0001_fffe;
	localparam logic [31:0] EXT_RAM_MASK   = 32'h0003_ffff;
	localparam logic [31:0] INT_RAM_MASK   = 32'h0000_7fff;
	localparam logic [31:0] IO_PAGE_MASK   = 32'hffff_fc00;
	localparam logic [31:0] IO_PAGE_BASE   = 32'h0400_0000;
	localparam logic [31:0] IO_MIR_MASK    = 32'hff00_ffff;
	localparam logic [31:0] IO_MIR_BASE    = 32'h0400_0800;
	localparam logic [31:0] IO_IDX_MASK    = 32'h0000_03ff;

	// Fixed costs outside cartridge space
	localparam logic [4:0] COST_EXT_RAM      = 5'd3;
	localparam logic [4:0] COST_EXT_RAM_WORD = 5'd6;
	localparam logic [4:0] COST_VIDEO        = 5'd1;
	localparam logic [4:0] COST_VIDEO_WORD   = 5'd2;
	localparam logic [4:0] COST_DEFAULT      = 5'd1;

endpackage

`default_nettype wire

### design/bawt_decode.sv
// Address decoder: routes a bus access to a target and forms the target address.
`default_nettype none

module bawt_decode import bawt_pkg::*; (
	input  wire cmd_t        cmd,
	input  wire logic [31:0] addr,
	output tgt_t             tgt,
	output logic [31:0]      taddr
);

	// Target select from the address map
	always_comb begin
		tgt   = TGT_NONE;
		taddr = '0;
		if (cmd == CMD_READ || cmd == CMD_WRITE) begin
			if (addr[CART_BIT]) begin
				tgt   = TGT_CART;
				taddr = addr;
			end else begin
				unique case (addr[26:24])
					MAP_BOOT_LO, MAP_BOOT_HI: begin
						// writes to boot rom are dropped
						if (cmd == CMD_READ) begin
							tgt   = TGT_BOOT_ROM;
							taddr = addr;
						end
					end
					MAP_EXT_RAM: begin
						tgt   = TGT_EXT_RAM;
						taddr = addr & EXT_RAM_MASK;
					end
					MAP_INT_RAM: begin
						tgt   = TGT_INT_RAM;
						taddr = addr & INT_RAM_MASK;
					end
					MAP_IO: begin
						if ((addr & IO_PAGE_MASK) == IO_PAGE_BASE) begin
							tgt   = TGT_IO_REG;
							taddr = addr & IO_IDX_MASK;
						end else if ((addr & IO_MIR_MASK) == IO_MIR_BASE) begin
							tgt   = TGT_IO_MIRROR;
							taddr = IO_MIR_BASE | {30'd0, addr[1:0]};
						end else begin
							tgt   = TGT_IO_UNMAP;
							taddr = addr;
						end
					end
					MAP_PALETTE: begin
						tgt   = TGT_PALETTE;
						taddr = addr;
					end
					MAP_VRAM: begin
						tgt   = TGT_VRAM;
						taddr = addr;
					end
					default: begin
						tgt   = TGT_OAM;
						taddr = addr;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### design/bawt_timing.sv
// Wait-state timing: region N/S registers, idle flag and per-access cost.
`default_nettype none

module bawt_timing import bawt_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [3:0]  cfg_data,
	input  wire              adv,
	input  wire cmd_t        cmd,
	input  wire logic [31:0] addr,
	input  wire logic [1:0]  size,
	input  wire              hint,
	output logic [4:0]       wait_cycles,
	output logic             idle_flag
);

	logic [3:0] nwait_q [4];
	logic [3:0] swait_q [4];
	logic       idle_flag_q;
	logic [3:0] n_sel;
	logic [3:0] s_sel;
	logic       word;
	logic       seq;

	// Wait-state register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				nwait_q[i] <= NWAIT_RESET;
				swait_q[i] <= SWAIT_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				IDX_NWAIT0: nwait_q[0] <= cfg_data;
				IDX_NWAIT1: nwait_q[1] <= cfg_data;
				IDX_NWAIT2: nwait_q[2] <= cfg_data;
				IDX_NWAIT3: nwait_q[3] <= cfg_data;
				IDX_SWAIT0: swait_q[0] <= cfg_data;
				IDX_SWAIT1: swait_q[1] <= cfg_data;
				IDX_SWAIT2: swait_q[2] <= cfg_data;
				default:    swait_q[3] <= cfg_data;
			endcase
		end
	end

	// Idle in cartridge space sets the flag; any read or write clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_flag_q <= 1'b0;
		end else if (adv) begin
			if (cmd == CMD_IDLE) begin
				if (addr[CART_BIT])
					idle_flag_q <= 1'b1;
			end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
				idle_flag_q <= 1'b0;
			end
		end
	end

	assign idle_flag = idle_flag_q;
	assign n_sel = nwait_q[addr[26:25]];
	assign s_sel = swait_q[addr[26:25]];
	assign word  = (size == SIZE_WORD);
	assign seq   = hint && ((addr & SEQ_BOUND_MASK) != '0) && !idle_flag_q;

	// Access cost; flag is sampled before this beat updates it
	always_comb begin
		wait_cycles = '0;
		if (cmd == CMD_READ || cmd == CMD_WRITE) begin
			if (addr[CART_BIT]) begin
				if (seq)
					wait_cycles = word ? {s_sel, 1'b0} : {1'b0, s_sel};
				else
					wait_cycles = word ? ({1'b0, n_sel} + {1'b0, s_sel}) : {1'b0, n_sel};
			end else begin
				case (addr[26:24])
					MAP_EXT_RAM:           wait_cycles = word ? COST_EXT_RAM_WORD : COST_EXT_RAM;
					MAP_PALETTE, MAP_VRAM: wait_cycles = word ? COST_VIDEO_WORD : COST_VIDEO;
					default:               wait_cycles = COST_DEFAULT;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

### design/bus_access_decode_and_wait_timing.sv
// Top level of the bus access decoder with wait-state timing.
`default_nettype none

// Each accepted input beat is one bus event (read, write or idle) and gives
// exactly one result beat: the wait-cycle count, the target and the address
// handed to that target. One beat is accepted every cycle while the output
// side is not stalled; in the input register, decode and the N/S wait lookup
// run, and the result is then captured in the output register. The idle flag
// is read and updated as a beat leaves the input register, so beats are timed
// strictly in arrival order. The user must write wait-state registers over the
// cfg port only while no beat is in flight; the block does not enforce this.

module bus_access_decode_and_wait_timing import bawt_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [3:0]  cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // [31:0] address, [33:32] access_size, [34] sequential_hint
	input  wire  [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [4:0] wait_cycles, [36:5] target_address
	output logic [3:0]  m_tuser    // [3:0] target
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [31:0] addr_s1;
	logic [1:0]  size_s1;
	logic        hint_s1;
	logic        valid_s2;
	logic [4:0]  wait_s2;
	tgt_t        tgt_s2;
	logic [31:0] taddr_s2;
	logic        adv_s1;
	logic        s2_free;
	logic [4:0]  wait_c;
	tgt_t        tgt_c;
	logic [31:0] taddr_c;
	logic        idle_flag;

	assign s2_free  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tuser);
			addr_s1 <= s_tdata[31:0];
			size_s1 <= s_tdata[33:32];
			hint_s1 <= s_tdata[34];
		end
	end

	bawt_decode u_decode (
		.cmd   (cmd_s1),
		.addr  (addr_s1),
		.tgt   (tgt_c),
		.taddr (taddr_c)
	);

	bawt_timing u_timing (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.adv         (adv_s1),
		.cmd         (cmd_s1),
		.addr        (addr_s1),
		.size        (size_s1),
		.hint        (hint_s1),
		.wait_cycles (wait_c),
		.idle_flag   (idle_flag)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			wait_s2  <= wait_c;
			tgt_s2   <= tgt_c;
			taddr_s2 <= taddr_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, taddr_s2, wait_s2};
	assign m_tuser  = tgt_s2;

`ifndef SYNTHESIS
	// Cartridge idle beat leaving the input register must set the flag
	a_idle_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cmd_s1 == CMD_IDLE && addr_s1[CART_BIT] |=> idle_flag)
		else $error("idle flag not set after cartridge idle");

	// A read or write leaving the input register clears the flag
	a_access_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (cmd_s1 == CMD_READ || cmd_s1 == CMD_WRITE) |=> !idle_flag)
		else $error("idle flag not cleared by access");

	// A held input beat is not overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(addr_s1) && $stable(cmd_s1))
		else $error("input register lost a stalled beat");

	// Wait count stays within the largest cartridge cost
	a_wait_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:0] <= 5'd30)
		else $error("wait count out of range");
`endif

endmodule

`default_nettype wire
